[design/lapet_pkg.sv]
// Shared types, constants and arithmetic helpers of the Laplacian edge threshold block.
`timescale 1ns / 1ps

package lapet_pkg;

  localparam int GRAY_W    = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 11;
  localparam int SIZE_W    = 12;
  localparam int THR_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 24;
  localparam int SUM_W     = 12;
  localparam int NSLOT     = 4;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [THR_W-1:0]  THRESHOLD_RST    = 11'd26;

  // Luma weights in units of 1/256.
  localparam logic [7:0] LUMA_R = 8'd77;
  localparam logic [7:0] LUMA_G = 8'd150;
  localparam logic [7:0] LUMA_B = 8'd29;

  typedef struct packed {
    logic             edge_res;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_index;
  } res_t;

  function automatic logic [GRAY_W-1:0] to_gray(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b);
    logic [15:0] acc;
    acc = 16'(LUMA_R) * 16'(r) + 16'(LUMA_G) * 16'(g) + 16'(LUMA_B) * 16'(b) + 16'd128;
    return acc[15:8];
  endfunction

  // Four-neighbour Laplacian compared against the signed threshold.
  function automatic logic edge_of(input logic [GRAY_W-1:0] cn, input logic [GRAY_W-1:0] up,
                                   input logic [GRAY_W-1:0] dn, input logic [GRAY_W-1:0] lf,
                                   input logic [GRAY_W-1:0] rt, input logic [THR_W-1:0] thr);
    logic signed [SUM_W-1:0] sum;
    sum = $signed({2'b00, cn, 2'b00}) - $signed({4'b0000, up}) - $signed({4'b0000, dn})
        - $signed({4'b0000, lf}) - $signed({4'b0000, rt});
    return sum > $signed({thr[THR_W-1], thr});
  endfunction

endpackage

[design/lapet_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module lapet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/laplacian_edge_threshold_top.sv]
// Streaming 3x3 four-neighbour Laplacian edge detector with a programmable threshold.
`timescale 1ns / 1ps

// RGB pixels enter in raster order, one per beat, and are reduced to 8-bit gray.
// Each output beat carries an edge flag with its column and row; results trail the
// input by one row and one pixel, and the last row is flushed as its pixels arrive.
// A pixel is taken every clock while it leaves at most one result and the output is
// ready; else the input waits for the four-entry result register to drain, as after a
// last-row pixel (up to two) or a row end (up to four). The two line stores share one
// RAM word per column with one write port; the second write of a row end goes out in
// the following cycle. The input also pauses in the cycle after each configuration
// write. Sizes of zero count as one, and sizes above MAX_WIDTH or MAX_HEIGHT saturate.
// The user must write configuration only while idle; the block does not enforce it.
module laplacian_edge_threshold_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: red [7:0], green [15:8], blue [23:16]
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lapet_pkg::IN_W-1:0]           s_axis_tdata,
  // tdata: edge_res [0], column [11:1], row_index [22:12], zero [23]
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lapet_pkg::OUT_W-1:0]          m_axis_tdata,
  output logic                                 m_axis_tlast,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lapet_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lapet_pkg::CFG_DAT_W-1:0]      cfg_data_i
);
  import lapet_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LWW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int LWH  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
  localparam int WORD = 2 * GRAY_W;

  // Configuration registers.
  logic [SIZE_W-1:0] fw_q, fh_q;
  logic [THR_W-1:0]  thr_q;
  logic              cfg_hold_q;
  logic              cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q       <= FRAME_WIDTH_RST;
      fh_q       <= FRAME_HEIGHT_RST;
      thr_q      <= THRESHOLD_RST;
      cfg_hold_q <= 1'b0;
    end else begin
      cfg_hold_q <= cfg_we;
      if (cfg_we) begin
        case (cfg_index_i)
          CFG_FRAME_WIDTH:    fw_q  <= cfg_data_i;
          CFG_FRAME_HEIGHT:   fh_q  <= cfg_data_i;
          CFG_EDGE_THRESHOLD: thr_q <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Effective frame size and clamped position.
  logic [LWW-1:0] w_ext, w_eff;
  logic [LWH-1:0] h_ext, h_eff;
  logic [CW-1:0]  wm1;
  logic [RW-1:0]  hm1;
  logic [CW-1:0]  col_q, col_d, c;
  logic [RW-1:0]  row_q, row_d, r;
  logic           row_end, last_row;

  always_comb begin
    w_ext = LWW'(fw_q);
    h_ext = LWH'(fh_q);
    if (fw_q == '0) begin
      w_eff = LWW'(1);
    end else if (w_ext > LWW'(MAX_WIDTH)) begin
      w_eff = LWW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (fh_q == '0) begin
      h_eff = LWH'(1);
    end else if (h_ext > LWH'(MAX_HEIGHT)) begin
      h_eff = LWH'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
    wm1      = CW'(w_eff - LWW'(1));
    hm1      = RW'(h_eff - LWH'(1));
    c        = (LWW'(col_q) < w_eff) ? col_q : wm1;
    r        = (LWH'(row_q) < h_eff) ? row_q : hm1;
    row_end  = (c == wm1);
    last_row = (r == hm1);
  end

  logic in_acc;
  logic out_acc;

  always_comb begin
    if (row_end) begin
      col_d = '0;
      row_d = last_row ? '0 : r + RW'(1);
    end else begin
      col_d = c + CW'(1);
      row_d = r;
    end
  end

  // Line RAM word: upper row gray in the high byte, middle row gray in the low byte.
  logic            ram_we;
  logic [CW-1:0]   ram_waddr, ram_raddr;
  logic [WORD-1:0] ram_wdata, ram_rdata;
  logic            wr_en_q;
  logic [CW-1:0]   wr_addr_q, rd_addr_q;
  logic [WORD-1:0] wr_data_q;
  logic            pend_q;
  logic [CW-1:0]   pend_addr_q;
  logic [WORD-1:0] pend_data_q;
  logic [WORD-1:0] rd_word;

  lapet_ram #(
    .WIDTH(WORD),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // The read port always fetches the column of the next pixel to be taken.
  assign ram_raddr = in_acc ? col_d : c;
  // A write at the same edge as the read is forwarded here.
  assign rd_word   = (wr_en_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : ram_rdata;

  // Pixel datapath.
  logic [GRAY_W-1:0] g;
  logic [GRAY_W-1:0] mw0_q, mw1_q, mw2_q, cw0_q, cw1_q, up_prev_q;
  logic [GRAY_W-1:0] m0n, m1n, m2n, up_c;
  logic              c_ge1, c_ge2, r_ge1, r_ge2;
  logic [NSLOT-1:0]  en;
  res_t              res [NSLOT];

  always_comb begin
    g     = to_gray(s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]);
    m0n   = mw1_q;
    m1n   = mw2_q;
    m2n   = rd_word[GRAY_W-1:0];
    up_c  = rd_word[WORD-1:GRAY_W];
    c_ge1 = (c != '0);
    c_ge2 = c_ge1 && (c != CW'(1));
    r_ge1 = (r != '0);
    r_ge2 = r_ge1 && (r != RW'(1));

    en[0] = r_ge1 && c_ge1;
    en[1] = r_ge1 && row_end;
    en[2] = last_row && c_ge1;
    en[3] = last_row && row_end;

    res[0].edge_res  = edge_of(m1n, r_ge2 ? up_prev_q : m1n, cw0_q, c_ge2 ? m0n : m1n, m2n,
                               thr_q);
    res[0].column    = COL_W'(c - CW'(1));
    res[0].row_index = ROW_W'(r - RW'(1));

    res[1].edge_res  = edge_of(m2n, r_ge2 ? up_c : m2n, g, c_ge1 ? m1n : m2n, m2n, thr_q);
    res[1].column    = COL_W'(c);
    res[1].row_index = ROW_W'(r - RW'(1));

    res[2].edge_res  = edge_of(cw0_q, r_ge1 ? m1n : cw0_q, cw0_q, c_ge2 ? cw1_q : cw0_q, g,
                               thr_q);
    res[2].column    = COL_W'(c - CW'(1));
    res[2].row_index = ROW_W'(r);

    res[3].edge_res  = edge_of(g, r_ge1 ? m2n : g, g, c_ge1 ? cw0_q : g, g, thr_q);
    res[3].column    = COL_W'(c);
    res[3].row_index = ROW_W'(r);
  end

  // One RAM write per cycle; the second write of a row end is deferred to the next cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = c - CW'(1);
    ram_wdata = {m1n, cw0_q};
    if (pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_q;
      ram_wdata = pend_data_q;
    end else if (in_acc && c_ge1) begin
      ram_we = 1'b1;
    end else if (in_acc && row_end) begin
      ram_we    = 1'b1;
      ram_waddr = c;
      ram_wdata = {m2n, g};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      mw0_q   <= '0;
      mw1_q   <= '0;
      mw2_q   <= '0;
      cw0_q   <= '0;
      cw1_q   <= '0;
      wr_en_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      wr_en_q <= ram_we;
      pend_q  <= in_acc && c_ge1 && row_end;
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
        if (row_end) begin
          mw0_q <= '0;
          mw1_q <= '0;
          mw2_q <= '0;
          cw0_q <= '0;
          cw1_q <= '0;
        end else begin
          mw0_q <= m0n;
          mw1_q <= m1n;
          mw2_q <= m2n;
          cw0_q <= g;
          cw1_q <= cw0_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q   <= ram_waddr;
    wr_data_q   <= ram_wdata;
    rd_addr_q   <= ram_raddr;
    pend_addr_q <= c;
    pend_data_q <= {m2n, g};
    if (in_acc) begin
      up_prev_q <= up_c;
    end
  end

  // Result register: up to four results per pixel, sent lowest slot first.
  logic [NSLOT-1:0] v_q, v_rest;
  res_t             slot_q [NSLOT];
  res_t             cur;

  always_comb begin
    cur = slot_q[NSLOT-1];
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (v_q[i]) begin
        cur = slot_q[i];
      end
    end
    v_rest = v_q & (v_q - NSLOT'(1));
  end

  assign m_axis_tvalid = (v_q != '0);
  assign m_axis_tdata  = {1'b0, cur.row_index, cur.column, cur.edge_res};
  assign m_axis_tlast  = (v_rest == '0);
  assign out_acc       = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = !cfg_hold_q && ((v_q == '0) || ((v_rest == '0) && m_axis_tready));
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (in_acc) begin
      v_q <= en;
    end else if (out_acc) begin
      v_q <= v_rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < NSLOT; i++) begin
        slot_q[i] <= res[i];
      end
    end
  end

endmodule

[tb/sv/tb_laplacian_edge_threshold_top.sv]
// Self-checking testbench of the Laplacian edge threshold block: directed table, random frames, oversized sizes.
`timescale 1ns / 1ps

module tb_laplacian_edge_threshold_top;
  import lapet_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int MAX_W         = 2048;
  localparam int MAX_H         = 2048;
  localparam int RANDOM_PIXELS = 200;
  localparam int SAT_PIXELS    = 16;
  localparam int QUIET_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int PRINT_LIMIT   = 40;
  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic             edge_res;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row_index;
    logic             run_end;
  } edge_beat_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_KNOWN} row_kind_e;
  typedef enum logic [1:0] {PAT_NOISE, PAT_BINARY, PAT_RAMP} pattern_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DAT_W-1:0]   data;
    logic [IN_W-1:0]        rgb;
    logic                   edge_res;
  } plan_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  laplacian_edge_threshold_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Predictor state: line stores, windows, raster position and registers.
  logic [7:0]        upper_gray [MAX_W];
  logic [7:0]        middle_gray [MAX_W];
  logic [7:0]        cur_win [2];
  logic [7:0]        mid_win [3];
  int                col_pos;
  int                row_pos;
  logic [SIZE_W-1:0] width_now;
  logic [SIZE_W-1:0] height_now;
  logic signed [THR_W-1:0] thr_now;

  edge_beat_t pending_edges [$];
  plan_row_t  plan [$];
  edge_beat_t want_beat;
  edge_beat_t idle_beat;
  int  mismatches;
  int  beats_checked;
  int  pixels_sent;
  int  cfg_writes;
  int  frames_done;
  int  quiet_cycles;
  bit  calm;
  bit  hold_request;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int size_of(input int v, input int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  function automatic logic laplace_hit(input int cn, input int up, input int dn, input int lf,
                                       input int rt);
    return (4 * cn - up - dn - lf - rt) > int'(thr_now);
  endfunction

  // Advances the predictor by one pixel and returns the result beats it releases.
  function automatic int step_laplace(input logic [IN_W-1:0] rgb, output edge_beat_t res [4]);
    int w, h, c, r, gv, m0, m1, m2, c0, c1, n, up, lf;
    bit row_end, last_row;
    w = size_of(int'(width_now), MAX_W);
    h = size_of(int'(height_now), MAX_H);
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h - 1;
    row_end  = (c == w - 1);
    last_row = (r == h - 1);
    gv = (77 * rgb[7:0] + 150 * rgb[15:8] + 29 * rgb[23:16] + 128) >> 8;

    mid_win[0] = mid_win[1];
    mid_win[1] = mid_win[2];
    mid_win[2] = middle_gray[c];
    m0 = mid_win[0];
    m1 = mid_win[1];
    m2 = mid_win[2];
    c0 = cur_win[0];
    c1 = cur_win[1];
    n  = 0;

    // The row above is finished one pixel behind, plus its last pixel at a row end.
    if (r >= 1) begin
      if (c >= 1) begin
        up = (r >= 2) ? upper_gray[c - 1] : m1;
        lf = (c >= 2) ? m0 : m1;
        res[n] = '{laplace_hit(m1, up, c0, lf, m2), 11'(c - 1), 11'(r - 1), 1'b0};
        n++;
      end
      if (row_end) begin
        up = (r >= 2) ? upper_gray[c] : m2;
        lf = (c >= 1) ? m1 : m2;
        res[n] = '{laplace_hit(m2, up, gv, lf, m2), 11'(c), 11'(r - 1), 1'b0};
        n++;
      end
    end
    // The bottom row has no row below, so it is emitted as it arrives.
    if (last_row) begin
      if (c >= 1) begin
        up = (r >= 1) ? m1 : c0;
        lf = (c >= 2) ? c1 : c0;
        res[n] = '{laplace_hit(c0, up, c0, lf, gv), 11'(c - 1), 11'(r), 1'b0};
        n++;
      end
      if (row_end) begin
        up = (r >= 1) ? m2 : gv;
        lf = (c >= 1) ? c0 : gv;
        res[n] = '{laplace_hit(gv, up, gv, lf, gv), 11'(c), 11'(r), 1'b0};
        n++;
      end
    end
    if (n > 0) res[n - 1].run_end = 1'b1;

    if (c >= 1) begin
      upper_gray[c - 1]  = middle_gray[c - 1];
      middle_gray[c - 1] = 8'(c0);
    end
    if (row_end) begin
      upper_gray[c]  = middle_gray[c];
      middle_gray[c] = 8'(gv);
    end
    cur_win[1] = cur_win[0];
    cur_win[0] = 8'(gv);

    if (row_end) begin
      cur_win = '{default: '0};
      mid_win = '{default: '0};
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    return n;
  endfunction

  function automatic logic [IN_W-1:0] pick_pixel(input pattern_e pat, input int base);
    logic [7:0] lvl;
    case (pat)
      PAT_NOISE:  return {8'($urandom), 8'($urandom), 8'($urandom)};
      PAT_BINARY: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
      default: begin
        lvl = 8'(base + $urandom_range(0, 24));
        return {lvl, lvl, lvl};
      end
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    plan_row_t p;
    p.kind = ROW_CFG;
    p.idx = idx;
    p.data = data;
    p.rgb = '0;
    p.edge_res = 1'b0;
    return p;
  endfunction

  function automatic plan_row_t pix_row(input logic [IN_W-1:0] rgb);
    plan_row_t p;
    p = cfg_row(CFG_FRAME_WIDTH, '0);
    p.kind = ROW_PIX;
    p.rgb = rgb;
    return p;
  endfunction

  // A pixel of a 1x1 frame: the sum is always zero, so only the threshold decides.
  function automatic plan_row_t known_row(input logic [IN_W-1:0] rgb, input logic e);
    plan_row_t p;
    p = pix_row(rgb);
    p.kind = ROW_KNOWN;
    p.edge_res = e;
    return p;
  endfunction

  function automatic void queue_beat(input edge_beat_t b);
    pending_edges.insert(pending_edges.size(), b);
  endfunction

  function automatic void add_row(input plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Called at a falling edge; returns at the falling edge after the beat was taken.
  task automatic send_pixel(input logic [IN_W-1:0] rgb, input bit typed, input edge_beat_t known);
    edge_beat_t got [4];
    int n;
    while (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rgb;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = step_laplace(rgb, got);
    if (typed) queue_beat(known);
    else for (int k = 0; k < n; k++) queue_beat(got[k]);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Stops offering pixels until every expected beat is out and the pipeline has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_edges.size() != 0) @(negedge clk_i);
    repeat (QUIET_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:    width_now = data;
      CFG_FRAME_HEIGHT:   height_now = data;
      CFG_EDGE_THRESHOLD: thr_now = data[THR_W-1:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 11);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (pending_edges.size() == 0) begin
        report_mismatch("result beat with nothing pending, row", m_axis_tdata[22:12], -1);
      end else begin
        want_beat = pending_edges.pop_front();
        if (m_axis_tdata[0] !== want_beat.edge_res)
          report_mismatch("edge flag", m_axis_tdata[0], want_beat.edge_res);
        if (m_axis_tdata[11:1] !== want_beat.column)
          report_mismatch("column", m_axis_tdata[11:1], want_beat.column);
        if (m_axis_tdata[22:12] !== want_beat.row_index)
          report_mismatch("row", m_axis_tdata[22:12], want_beat.row_index);
        if (m_axis_tdata[23] !== 1'b0)
          report_mismatch("padding bit", m_axis_tdata[23], 0);
        if (m_axis_tlast !== want_beat.run_end)
          report_mismatch("tlast", m_axis_tlast, want_beat.run_end);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    edge_beat_t known;
    pattern_e pat;
    int w_set, h_set, npix, base, frame_no, random_pixels;
    logic [IN_W-1:0] rgb;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_FRAME_WIDTH;
    cfg_data_i    = '0;
    calm          = 1'b0;
    hold_request  = 1'b0;
    mismatches    = 0;
    beats_checked = 0;
    pixels_sent   = 0;
    cfg_writes    = 0;
    frames_done   = 0;
    quiet_cycles  = 0;
    idle_beat     = '{1'b0, '0, '0, 1'b0};

    for (int i = 0; i < MAX_W; i++) begin
      upper_gray[i]  = '0;
      middle_gray[i] = '0;
    end
    cur_win    = '{default: '0};
    mid_win    = '{default: '0};
    col_pos    = 0;
    row_pos    = 0;
    width_now  = FRAME_WIDTH_RST;
    height_now = FRAME_HEIGHT_RST;
    thr_now    = THRESHOLD_RST;

    // 1x1 frames (sizes of zero count as one): the first pixel checks the reset threshold.
    add_row(cfg_row(CFG_FRAME_WIDTH, 12'd0));
    add_row(cfg_row(CFG_FRAME_HEIGHT, 12'd0));
    add_row(known_row(24'h000000, 1'b0));
    add_row(cfg_row(CFG_SPARE, 12'hABC));
    add_row(known_row(24'hFFFFFF, 1'b0));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'hFFF));
    add_row(known_row(24'hFF00FF, 1'b1));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'h000));
    add_row(known_row(24'h00FF00, 1'b0));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'hC00));
    add_row(known_row(24'h5A3C96, 1'b1));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'h3FF));
    add_row(known_row(24'hA5C369, 1'b0));
    // 3x3 frame, a white centre on black: the largest sum, just above the threshold.
    add_row(cfg_row(CFG_FRAME_WIDTH, 12'd3));
    add_row(cfg_row(CFG_FRAME_HEIGHT, 12'd3));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'h3FB));
    for (int i = 0; i < 9; i++) add_row(pix_row((i == 4) ? 24'hFFFFFF : 24'h000000));
    // The height shrinks below the current row, which then becomes the bottom row.
    add_row(cfg_row(CFG_FRAME_WIDTH, 12'd2));
    add_row(cfg_row(CFG_FRAME_HEIGHT, 12'd6));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'hC04));
    for (int i = 0; i < 4; i++) add_row(pix_row(24'(24'h0F1E2D * (i + 1))));
    add_row(cfg_row(CFG_FRAME_HEIGHT, 12'd1));
    add_row(pix_row(24'hFFFFFF));
    add_row(pix_row(24'h102030));
    // The width shrinks below the current column, which then ends the row.
    add_row(cfg_row(CFG_FRAME_WIDTH, 12'd4));
    add_row(cfg_row(CFG_FRAME_HEIGHT, 12'd2));
    add_row(cfg_row(CFG_EDGE_THRESHOLD, 12'd26));
    for (int i = 0; i < 6; i++) add_row(pix_row(24'(24'h3B2A19 * (i + 3))));
    add_row(cfg_row(CFG_FRAME_WIDTH, 12'd2));
    add_row(pix_row(24'hE0E0E0));

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: write_register(plan[i].idx, plan[i].data);
        ROW_KNOWN: begin
          known = '{plan[i].edge_res, '0, '0, 1'b1};
          send_pixel(plan[i].rgb, 1'b1, known);
        end
        default: send_pixel(plan[i].rgb, 1'b0, idle_beat);
      endcase
    end
    frames_done = 9;

    // Random whole frames, mostly small, each with fresh sizes and threshold.
    random_pixels = 0;
    frame_no = 0;
    while (random_pixels < RANDOM_PIXELS || frame_no <= 6) begin
      calm = (frame_no >= 4 && frame_no <= 6);
      if (frame_no == 1) begin
        w_set = 12;
        h_set = 6;
      end else begin
        case ($urandom_range(0, 9))
          0:       w_set = 0;
          1:       w_set = $urandom_range(9, 30);
          default: w_set = $urandom_range(1, 8);
        endcase
        h_set = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      end
      write_register(CFG_FRAME_WIDTH, 12'(w_set));
      write_register(CFG_FRAME_HEIGHT, 12'(h_set));
      if ($urandom_range(0, 4) == 0)
        write_register(CFG_EDGE_THRESHOLD, 12'(int'($urandom_range(0, 2040)) - 1020));
      else
        write_register(CFG_EDGE_THRESHOLD, 12'(int'($urandom_range(0, 100)) - 40));
      npix = size_of(w_set, MAX_W) * size_of(h_set, MAX_H);
      pat = ($urandom_range(0, 3) < 2) ? PAT_RAMP
          : ($urandom_range(0, 1) ? PAT_NOISE : PAT_BINARY);
      base = $urandom_range(0, 230);
      for (int p = 0; p < npix; p++) begin
        if (frame_no == 1 && p == 4) hold_request = 1'b1;
        if (frame_no == 2 && p == npix / 2) settle();
        rgb = pick_pixel(pat, base);
        send_pixel(rgb, 1'b0, idle_beat);
        random_pixels++;
      end
      frame_no++;
      frames_done++;
    end
    calm = 1'b0;

    // Oversized registers saturate: the start of a long row, then the top of a tall column.
    write_register(CFG_FRAME_WIDTH, 12'hFFF);
    write_register(CFG_FRAME_HEIGHT, 12'd1);
    write_register(CFG_EDGE_THRESHOLD, 12'(int'($urandom_range(0, 200)) - 100));
    for (int p = 0; p < SAT_PIXELS; p++) send_pixel(pick_pixel(PAT_NOISE, 0), 1'b0, idle_beat);
    write_register(CFG_FRAME_WIDTH, 12'd1);
    write_register(CFG_FRAME_HEIGHT, 12'hFFF);
    for (int p = 0; p < SAT_PIXELS; p++) send_pixel(pick_pixel(PAT_NOISE, 0), 1'b0, idle_beat);
    frames_done += 2;

    settle();
    repeat (2 * QUIET_CYCLES) @(negedge clk_i);

    $display("Covered %0d pixels in %0d frames with %0d register writes, zero to oversized sizes.",
             pixels_sent, frames_done, cfg_writes);
    $display("Compared %0d result beats, including mid-frame size cuts and a long stall.",
             beats_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
